[hw/rtl/euler_to_rotation_matrix_macros.svh]
// Assertion macros shared by the euler_to_rotation_matrix RTL.
// All macros assume a clock named clock and a reset named reset in scope.
`ifndef EULER_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_MACROS_SVH

// Implication checked outside reset.
`define E2R_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define E2R_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Condition that must hold in the cycle after reset was high.
`define E2R_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/e2r_pkg.sv]
// Shared types, constants and arithmetic helpers for the Euler-to-rotation block.
// No dependencies.
`timescale 1ns / 1ps

package e2r_pkg;

   localparam int XY_BITS  = 34;   // CORDIC x/y, Q.30
   localparam int Z_BITS   = 36;   // CORDIC residual angle, Q.30
   localparam int Q30_BITS = 32;   // clamped cos/sin and products, Q.30

   localparam logic signed [Z_BITS-1:0]  HALF_PI = 36'sd1686629713;
   localparam logic signed [Z_BITS-1:0]  PI      = 36'sd3373259426;
   localparam logic signed [XY_BITS-1:0] GAIN    = 34'sd652032874;
   localparam logic signed [XY_BITS-1:0] ONE_XY  = 34'sd1073741824;

   typedef enum logic {
      SEQ_ZYX = 1'b0,
      SEQ_XYZ = 1'b1
   } seq_type;

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
      logic                      flip;
   } lane_type;

   // lane 0: about x, lane 1: about y, lane 2: about z
   typedef struct packed {
      lane_type [2:0] lane;
      seq_type        seq;
   } cell_type;

   function automatic logic signed [Z_BITS-1:0] atan_q30(input logic [4:0] idx);
      logic signed [Z_BITS-1:0] r;
      case (idx)
         5'd0:  r = 36'sh03243F6A8;
         5'd1:  r = 36'sh01DAC6705;
         5'd2:  r = 36'sh00FADBAFC;
         5'd3:  r = 36'sh007F56EA6;
         5'd4:  r = 36'sh003FEAB76;
         5'd5:  r = 36'sh001FFD55B;
         5'd6:  r = 36'sh000FFFAAA;
         5'd7:  r = 36'sh0007FFF55;
         5'd8:  r = 36'sh0003FFFEA;
         5'd9:  r = 36'sh0001FFFFD;
         5'd10: r = 36'sh0000FFFFF;
         5'd11: r = 36'sh00007FFFF;
         5'd12: r = 36'sh00003FFFF;
         5'd13: r = 36'sh00001FFFF;
         5'd14: r = 36'sh00000FFFF;
         5'd15: r = 36'sh000007FFF;
         5'd16: r = 36'sh000003FFF;
         5'd17: r = 36'sh000001FFF;
         5'd18: r = 36'sh000000FFF;
         5'd19: r = 36'sh0000007FF;
         5'd20: r = 36'sh0000003FF;
         5'd21: r = 36'sh0000001FF;
         5'd22: r = 36'sh0000000FF;
         5'd23: r = 36'sh00000007F;
         5'd24: r = 36'sh00000003F;
         5'd25: r = 36'sh00000001F;
         5'd26: r = 36'sh00000000F;
         5'd27: r = 36'sh000000008;
         5'd28: r = 36'sh000000004;
         5'd29: r = 36'sh000000002;
         5'd30: r = 36'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q.30 product, rounded half up
   function automatic logic signed [Q30_BITS-1:0] mul30(
      input logic signed [Q30_BITS-1:0] a,
      input logic signed [Q30_BITS-1:0] b
   );
      logic signed [63:0] pr;
      pr = 64'(a) * 64'(b) + 64'sd536870912;
      return pr[61:30];
   endfunction

endpackage

[hw/rtl/e2r_cordic_cell.sv]
// One CORDIC rotation step for the three angles, registered, with stream handshake.
// Depends on e2r_pkg.
`timescale 1ns / 1ps

module e2r_cordic_cell import e2r_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  cell_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output cell_type dn_data
);

   logic     valid_ff;
   cell_type data_ff;
   cell_type data_in;
   logic     load;

   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;

   always_comb begin
      data_in     = up_data;
      for (int k = 0; k < 3; k++) begin
         if (!up_data.lane[k].z[Z_BITS-1]) begin
            data_in.lane[k].x = up_data.lane[k].x - (up_data.lane[k].y >>> STEP);
            data_in.lane[k].y = up_data.lane[k].y + (up_data.lane[k].x >>> STEP);
            data_in.lane[k].z = up_data.lane[k].z - atan_q30(5'(STEP));
         end else begin
            data_in.lane[k].x = up_data.lane[k].x + (up_data.lane[k].y >>> STEP);
            data_in.lane[k].y = up_data.lane[k].y - (up_data.lane[k].x >>> STEP);
            data_in.lane[k].z = up_data.lane[k].z + atan_q30(5'(STEP));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[hw/rtl/e2r_matrix.sv]
// Sign fix and clamp of cos/sin, two product stages and the entry combine/saturate stage.
// Depends on e2r_pkg.
`timescale 1ns / 1ps

module e2r_matrix import e2r_pkg::*; #(
   parameter int ENTRY_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  cell_type                  up_data,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [9*ENTRY_BITS-1:0]   dn_entries
);

   localparam int     SUM_BITS = Q30_BITS + 2;
   localparam int     SH       = 32 - ENTRY_BITS;
   localparam longint RND      = (longint'(1) << SH) >> 1;
   localparam longint LIM      = longint'(1) << (ENTRY_BITS - 2);

   typedef logic signed [Q30_BITS-1:0] q30_type;
   typedef logic signed [SUM_BITS-1:0] sum_type;

   typedef struct packed {
      q30_type [2:0] c;
      q30_type [2:0] s;
      seq_type       seq;
   } trig_type;

   typedef struct packed {
      q30_type p, q, cccb, cbsc, scca, scsa, ccca, ccsa, cbsa, cbca, sb, cc, sc;
      seq_type seq;
   } prod1_type;

   typedef struct packed {
      q30_type ccp, scp, ccq, scq, cccb, cbsc, scca, scsa, ccca, ccsa, cbsa, cbca, sb;
      seq_type seq;
   } prod2_type;

   function automatic logic [ENTRY_BITS-1:0] to_entry(input sum_type v);
      logic signed [SUM_BITS:0] r;
      r = ((SUM_BITS+1)'(v) + (SUM_BITS+1)'(RND)) >>> SH;
      if (r > (SUM_BITS+1)'(LIM)) begin
         r = (SUM_BITS+1)'(LIM);
      end else if (r < -(SUM_BITS+1)'(LIM)) begin
         r = -(SUM_BITS+1)'(LIM);
      end
      return r[ENTRY_BITS-1:0];
   endfunction

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic ld_a, ld_b, ld_c, ld_d;

   trig_type  a_ff, a_in;
   prod1_type b_ff, b_in;
   prod2_type c_ff, c_in;
   logic [9*ENTRY_BITS-1:0] d_ff, d_in;

   assign ld_d     = !vd_ff || dn_ready;
   assign ld_c     = !vc_ff || ld_d;
   assign ld_b     = !vb_ff || ld_c;
   assign ld_a     = !va_ff || ld_b;
   assign up_ready = ld_a;

   // undo the half-turn fold, then clamp to +/-1
   always_comb begin
      logic signed [XY_BITS-1:0] xf, yf;
      a_in.seq = up_data.seq;
      for (int k = 0; k < 3; k++) begin
         xf = up_data.lane[k].flip ? -up_data.lane[k].x : up_data.lane[k].x;
         yf = up_data.lane[k].flip ? -up_data.lane[k].y : up_data.lane[k].y;
         if (xf > ONE_XY) xf = ONE_XY;
         else if (xf < -ONE_XY) xf = -ONE_XY;
         if (yf > ONE_XY) yf = ONE_XY;
         else if (yf < -ONE_XY) yf = -ONE_XY;
         a_in.c[k] = Q30_BITS'(xf);
         a_in.s[k] = Q30_BITS'(yf);
      end
   end

   // both orders use the same set of products; only the combine differs
   always_comb begin
      b_in.p    = mul30(a_ff.s[1], a_ff.s[0]);
      b_in.q    = mul30(a_ff.s[1], a_ff.c[0]);
      b_in.cccb = mul30(a_ff.c[2], a_ff.c[1]);
      b_in.cbsc = mul30(a_ff.c[1], a_ff.s[2]);
      b_in.scca = mul30(a_ff.s[2], a_ff.c[0]);
      b_in.scsa = mul30(a_ff.s[2], a_ff.s[0]);
      b_in.ccca = mul30(a_ff.c[2], a_ff.c[0]);
      b_in.ccsa = mul30(a_ff.c[2], a_ff.s[0]);
      b_in.cbsa = mul30(a_ff.c[1], a_ff.s[0]);
      b_in.cbca = mul30(a_ff.c[1], a_ff.c[0]);
      b_in.sb   = a_ff.s[1];
      b_in.cc   = a_ff.c[2];
      b_in.sc   = a_ff.s[2];
      b_in.seq  = a_ff.seq;
   end

   always_comb begin
      c_in.ccp  = mul30(b_ff.cc, b_ff.p);
      c_in.scp  = mul30(b_ff.sc, b_ff.p);
      c_in.ccq  = mul30(b_ff.cc, b_ff.q);
      c_in.scq  = mul30(b_ff.sc, b_ff.q);
      c_in.cccb = b_ff.cccb;
      c_in.cbsc = b_ff.cbsc;
      c_in.scca = b_ff.scca;
      c_in.scsa = b_ff.scsa;
      c_in.ccca = b_ff.ccca;
      c_in.ccsa = b_ff.ccsa;
      c_in.cbsa = b_ff.cbsa;
      c_in.cbca = b_ff.cbca;
      c_in.sb   = b_ff.sb;
      c_in.seq  = b_ff.seq;
   end

   always_comb begin
      sum_type m [9];
      case (c_ff.seq)
         SEQ_ZYX: begin
            m[0] = SUM_BITS'(c_ff.cccb);
            m[1] = SUM_BITS'(c_ff.ccp) - SUM_BITS'(c_ff.scca);
            m[2] = SUM_BITS'(c_ff.ccq) + SUM_BITS'(c_ff.scsa);
            m[3] = SUM_BITS'(c_ff.cbsc);
            m[4] = SUM_BITS'(c_ff.scp) + SUM_BITS'(c_ff.ccca);
            m[5] = SUM_BITS'(c_ff.scq) - SUM_BITS'(c_ff.ccsa);
            m[6] = -SUM_BITS'(c_ff.sb);
            m[7] = SUM_BITS'(c_ff.cbsa);
            m[8] = SUM_BITS'(c_ff.cbca);
         end
         SEQ_XYZ: begin
            m[0] = SUM_BITS'(c_ff.cccb);
            m[1] = -SUM_BITS'(c_ff.cbsc);
            m[2] = SUM_BITS'(c_ff.sb);
            m[3] = SUM_BITS'(c_ff.ccp) + SUM_BITS'(c_ff.scca);
            m[4] = SUM_BITS'(c_ff.ccca) - SUM_BITS'(c_ff.scp);
            m[5] = -SUM_BITS'(c_ff.cbsa);
            m[6] = SUM_BITS'(c_ff.scsa) - SUM_BITS'(c_ff.ccq);
            m[7] = SUM_BITS'(c_ff.scq) + SUM_BITS'(c_ff.ccsa);
            m[8] = SUM_BITS'(c_ff.cbca);
         end
         default: begin
            for (int k = 0; k < 9; k++) m[k] = '0;
         end
      endcase
      for (int k = 0; k < 9; k++) begin
         d_in[k*ENTRY_BITS +: ENTRY_BITS] = to_entry(m[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (ld_a) va_ff <= up_valid;
         if (ld_b) vb_ff <= va_ff;
         if (ld_c) vc_ff <= vb_ff;
         if (ld_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a && up_valid) a_ff <= a_in;
      if (ld_b && va_ff)    b_ff <= b_in;
      if (ld_c && vb_ff)    c_ff <= c_in;
      if (ld_d && vc_ff)    d_ff <= d_in;
   end

   assign dn_valid   = vd_ff;
   assign dn_entries = d_ff;

endmodule

[hw/rtl/euler_to_rotation_matrix.sv]
// A req beat passes one input stage, one cell per CORDIC step and four matrix
// stages on its way to the rsp beat. Throughput: one beat per cycle;
// every stage has its own valid and fills bubbles, so a stalled rsp beat blocks
// req only once every stage ahead of the input is full. Reset clears all valid
// flags and sets the axis sequence to zyx; csr writes are always accepted.
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_macros.svh"

module euler_to_rotation_matrix import e2r_pkg::*; #(
   parameter int ANGLE_BITS   = 16,
   parameter int ENTRY_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // angle_first, angle_second, angle_third
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic [((9*ENTRY_BITS+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                     csr_tvalid,
   output logic                                     csr_tready,
   // axis_sequence
   input  logic [7:0]                               csr_tdata
);

   localparam int RSP_W     = ((9*ENTRY_BITS+7)/8)*8;
   localparam int ANG_SHIFT = 33 - ANGLE_BITS;   // to Q.30
   localparam int ENT_LIM   = 1 << (ENTRY_BITS - 2);

   seq_type  seq_ff;
   logic     in_v_ff;
   cell_type in_ff, in_in;
   logic     load0;

   logic     link_valid [CORDIC_STEPS+1];
   logic     link_ready [CORDIC_STEPS+1];
   cell_type link_data  [CORDIC_STEPS+1];

   logic [9*ENTRY_BITS-1:0] entries;
   logic signed [ENTRY_BITS-1:0] rsp_m00;

   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_ZYX;
      end else if (csr_tvalid) begin
         seq_ff <= seq_type'(csr_tdata[0]);
      end
   end

   // widen to Q.30 and fold into +/-pi/2
   always_comb begin
      logic signed [Z_BITS-1:0] zw;
      in_in.seq = seq_ff;
      for (int k = 0; k < 3; k++) begin
         zw = Z_BITS'($signed(req_tdata[k*ANGLE_BITS +: ANGLE_BITS])) <<< ANG_SHIFT;
         in_in.lane[k].x    = GAIN;
         in_in.lane[k].y    = '0;
         in_in.lane[k].flip = 1'b0;
         in_in.lane[k].z    = zw;
         if (zw > HALF_PI) begin
            in_in.lane[k].z    = zw - PI;
            in_in.lane[k].flip = 1'b1;
         end else if (zw < -HALF_PI) begin
            in_in.lane[k].z    = zw + PI;
            in_in.lane[k].flip = 1'b1;
         end
      end
   end

   assign load0      = !in_v_ff || link_ready[0];
   assign req_tready = load0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (load0) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (load0 && req_tvalid) begin
         in_ff <= in_in;
      end
   end

   assign link_valid[0] = in_v_ff;
   assign link_data[0]  = in_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      e2r_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_data  (link_data[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_data  (link_data[i+1])
      );
   end

   e2r_matrix #(.ENTRY_BITS(ENTRY_BITS)) u_matrix (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[CORDIC_STEPS]),
      .up_ready   (link_ready[CORDIC_STEPS]),
      .up_data    (link_data[CORDIC_STEPS]),
      .dn_valid   (rsp_tvalid),
      .dn_ready   (rsp_tready),
      .dn_entries (entries)
   );

   assign rsp_tdata = RSP_W'(entries);
   assign rsp_m00   = rsp_tdata[ENTRY_BITS-1:0];

   `E2R_ASSERT_IMP(a_drain_frees_input, rsp_tready, req_tready)
   `E2R_ASSERT_NEXT(a_csr_takes, csr_tvalid, seq_ff == seq_type'($past(csr_tdata[0])))
   `E2R_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid)
   `E2R_ASSERT_IMP(a_m00_range, rsp_tvalid, (rsp_m00 <= ENT_LIM) && (rsp_m00 >= -ENT_LIM))

endmodule

[tb/sv/euler_to_rotation_matrix_test.sv]
// Self-checking bench for euler_to_rotation_matrix: directed and random angle
// beats, both axis sequences, checked against a bit-exact CORDIC matrix predictor.
// Depends on e2r_pkg and the euler_to_rotation_matrix RTL.
`timescale 1ns / 1ps

module euler_to_rotation_matrix_test;
   import e2r_pkg::*;

   localparam int LATENCY    = 21;
   localparam int STALL_LIMIT = 4000;
   localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;  // pi in Q3.13
   localparam logic signed [15:0] QUARTER   = 16'sd12868;  // pi/2 in Q3.13

   typedef struct packed {
      logic signed [8:0][15:0] m;
   } matrix_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic         csr_tvalid;
   logic         csr_tready;
   logic [7:0]   csr_tdata;

   seq_type    seq_model;
   bit         stall_en;
   int         error_count;
   int         quiet_cycles;
   matrix_type matrix_queue[$];

   longint atan_table[16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF};

   euler_to_rotation_matrix DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_tvalid(csr_tvalid), .csr_tready(csr_tready), .csr_tdata(csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
      if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
      return v;
   endfunction

   function automatic void cordic_cos_sin(logic signed [15:0] angle,
                                          output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(angle) <<< 17;
      x = longint'(GAIN);
      y = 0;
      flip = 0;
      // fold into +-pi/2, negate the pair afterwards
      if (z > longint'(HALF_PI)) begin
         z -= longint'(PI);
         flip = 1;
      end else if (z < -longint'(HALF_PI)) begin
         z += longint'(PI);
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_table[i];
         end else begin
            x += dx; y -= dy; z += atan_table[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
   endfunction

   function automatic logic signed [15:0] entry_q14(longint v);
      v = (v + (64'sd1 <<< 15)) >>> 16;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   function automatic matrix_type rotation_matrix(logic [47:0] angles, seq_type order);
      longint ca, sa, cb, sb, cc, sc, p, q;
      longint m[9];
      matrix_type r;
      cordic_cos_sin(angles[15:0], ca, sa);
      cordic_cos_sin(angles[31:16], cb, sb);
      cordic_cos_sin(angles[47:32], cc, sc);
      if (order == SEQ_ZYX) begin
         p = q30_mul(sb, sa);
         q = q30_mul(sb, ca);
         m[0] = q30_mul(cc, cb);
         m[1] = q30_mul(cc, p) - q30_mul(sc, ca);
         m[2] = q30_mul(cc, q) + q30_mul(sc, sa);
         m[3] = q30_mul(sc, cb);
         m[4] = q30_mul(sc, p) + q30_mul(cc, ca);
         m[5] = q30_mul(sc, q) - q30_mul(cc, sa);
         m[6] = -sb;
         m[7] = q30_mul(cb, sa);
         m[8] = q30_mul(cb, ca);
      end else begin
         p = q30_mul(sa, sb);
         q = q30_mul(ca, sb);
         m[0] = q30_mul(cb, cc);
         m[1] = -q30_mul(cb, sc);
         m[2] = sb;
         m[3] = q30_mul(p, cc) + q30_mul(ca, sc);
         m[4] = q30_mul(ca, cc) - q30_mul(p, sc);
         m[5] = -q30_mul(sa, cb);
         m[6] = q30_mul(sa, sc) - q30_mul(q, cc);
         m[7] = q30_mul(q, sc) + q30_mul(sa, cc);
         m[8] = q30_mul(ca, cb);
      end
      for (int k = 0; k < 9; k++) r.m[k] = entry_q14(m[k]);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      matrix_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (matrix_queue.size() == 0) begin
            report_mismatch("unexpected rsp beat", 0, 0);
         end else begin
            want = matrix_queue.pop_front();
            for (int k = 0; k < 9; k++)
               if ($signed(rsp_tdata[16*k +: 16]) != $signed(want.m[k]))
                  report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                  int'($signed(rsp_tdata[16*k +: 16])),
                                  int'($signed(want.m[k])));
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= !stall_en || ($urandom_range(99) >= 20);

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("euler_to_rotation_matrix_test failed");
         $finish;
      end
   end

   task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      @(negedge clock);
      while (stall_en && $urandom_range(99) < 20) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {az, ay, ax};
      do @(posedge clock); while (!req_tready);
      matrix_queue.push_back(rotation_matrix(req_tdata, seq_model));
   endtask

   // sender holds off until the pipe is empty
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (matrix_queue.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_seq_reg(logic [7:0] value);
      drain_results();
      @(negedge clock);
      csr_tvalid = 1'b1;
      csr_tdata  = value;
      do @(posedge clock); while (!csr_tready);
      seq_model = seq_type'(value[0]);
      @(negedge clock);
      csr_tvalid = 1'b0;
   endtask

   function automatic logic signed [15:0] random_angle();
      case ($urandom_range(9))
         0: return 16'($urandom());                    // full field
         1: return 16'(QUARTER + $signed($urandom_range(4)) - 2);
         2: return 16'(-QUARTER + $signed($urandom_range(4)) - 2);
         default: return 16'($signed($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
      endcase
   endfunction

   task automatic test_directed_angles();
      logic signed [15:0] corner[10] = '{16'sd0, ANGLE_MAX, -ANGLE_MAX, 16'sh7FFF,
         16'sh8000, QUARTER, -QUARTER, QUARTER - 16'sd1, 16'sd1, -16'sd1};
      for (int i = 0; i < 10; i++)
         send_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]);
      send_angles(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
   endtask

   task automatic test_random_angles(int count);
      for (int i = 0; i < count; i++)
         send_angles(random_angle(), random_angle(), random_angle());
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_tvalid  = 1'b0;
      csr_tdata   = '0;
      seq_model   = SEQ_ZYX;
      stall_en    = 1'b0;
      error_count = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_angles();            // reset value of the sequence
      write_seq_reg(8'h01);
      test_directed_angles();
      write_seq_reg(8'hFE);              // upper bits ignored, zyx
      test_random_angles(250);           // no idling on either side
      stall_en = 1'b1;
      test_random_angles(125);
      write_seq_reg(8'h81);
      test_random_angles(125);
      write_seq_reg(8'h00);
      test_random_angles(125);
      write_seq_reg(8'hFF);
      test_random_angles(125);
      drain_results();

      if (error_count == 0)
         $display("euler_to_rotation_matrix_test passed");
      else
         $display("euler_to_rotation_matrix_test failed");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/e2r_pkg.sv
hw/rtl/e2r_cordic_cell.sv
hw/rtl/e2r_matrix.sv
hw/rtl/euler_to_rotation_matrix.sv
tb/sv/euler_to_rotation_matrix_test.sv
